// File: hdl/fcsg_pkg.sv
// fcsg_pkg: shared types, constants and helper functions for the sound generator
// used by every module in hdl/
package fcsg_pkg;

	localparam int FRAME_PERIOD = 8192;
	localparam int FRAME_CNT_W = $clog2(FRAME_PERIOD + 1);

	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_WRITE = 2'd2;

	localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd95;

	localparam logic [7:0] ADDR_NR10 = 8'h10;
	localparam logic [7:0] ADDR_NR11 = 8'h11;
	localparam logic [7:0] ADDR_NR12 = 8'h12;
	localparam logic [7:0] ADDR_NR13 = 8'h13;
	localparam logic [7:0] ADDR_NR14 = 8'h14;
	localparam logic [7:0] ADDR_NR21 = 8'h16;
	localparam logic [7:0] ADDR_NR22 = 8'h17;
	localparam logic [7:0] ADDR_NR23 = 8'h18;
	localparam logic [7:0] ADDR_NR24 = 8'h19;
	localparam logic [7:0] ADDR_NR30 = 8'h1A;
	localparam logic [7:0] ADDR_NR31 = 8'h1B;
	localparam logic [7:0] ADDR_NR32 = 8'h1C;
	localparam logic [7:0] ADDR_NR33 = 8'h1D;
	localparam logic [7:0] ADDR_NR34 = 8'h1E;
	localparam logic [7:0] ADDR_NR41 = 8'h20;
	localparam logic [7:0] ADDR_NR42 = 8'h21;
	localparam logic [7:0] ADDR_NR43 = 8'h22;
	localparam logic [7:0] ADDR_NR44 = 8'h23;
	localparam logic [7:0] ADDR_NR50 = 8'h24;
	localparam logic [7:0] ADDR_NR51 = 8'h25;
	localparam logic [7:0] ADDR_NR52 = 8'h26;

	// register page after reset: all zero but the control byte (slot 0x16)
	localparam logic [31:0][7:0] REGS_RST = 256'h80 << (8 * 22);

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] address;
		logic [7:0] write_data;
	} req_t;

	typedef struct packed {
		logic        result_kind;
		logic [7:0]  read_data;
		logic [14:0] left_sample;
		logic [14:0] right_sample;
	} rsp_t;

	// channel values that the mixer needs from the core state
	typedef struct packed {
		logic [3:0]      active;
		logic [3:0]      dac_on;
		logic [1:0][1:0] duty;
		logic [1:0][2:0] sq_phase;
		logic [2:0][3:0] env_vol;
		logic [4:0]      wave_phase;
		logic [1:0]      wave_level;
		logic [7:0]      wave_byte;
		logic            noise_bit;
		logic [7:0]      pan;
		logic [7:0]      vol;
	} mix_in_t;

	function automatic logic duty_bit(input logic [1:0] d, input logic [2:0] ph);
		logic [7:0] pat;
		case (d)
			2'd0:    pat = 8'b00000001;
			2'd1:    pat = 8'b10000001;
			2'd2:    pat = 8'b10000111;
			default: pat = 8'b01111110;
		endcase
		return pat[ph];
	endfunction

	function automatic logic [15:0] noise_reload(input logic [7:0] c);
		logic [7:0] base;
		case (c[2:0])
			3'd0:    base = 8'd8;
			3'd1:    base = 8'd16;
			3'd2:    base = 8'd32;
			3'd3:    base = 8'd48;
			3'd4:    base = 8'd64;
			3'd5:    base = 8'd80;
			3'd6:    base = 8'd96;
			default: base = 8'd112;
		endcase
		return 16'({8'd0, base} << c[7:4]);
	endfunction

	function automatic logic [15:0] sq_reload(input logic [10:0] f);
		return {3'd0, 13'(12'd2048 - {1'b0, f})} << 2;
	endfunction

	function automatic logic [15:0] wv_reload(input logic [10:0] f);
		return {4'd0, 12'(12'd2048 - {1'b0, f})} << 1;
	endfunction

endpackage

// File: hdl/four_channel_sound_generator.sv
// four_channel_sound_generator: top level with input hold and output queue
// depends on fcsg_pkg, fcsg_core
//
//  port set    | direction | carries
//  in_*        | in        | req_t word: tick, register read or write
//  out_*       | out       | rsp_t word: read byte or stereo sample
//  cfg_*       | in        | sample_period write
//
// every word is processed in the cycle after acceptance, one word per clock while in_stall is low
// a read, or a tick that ends a sample period, yields a result; it is registered in the core
// and then written into the output queue, from which it is offered
// the output queue holds four words; in_stall rises when queued results plus words
// in flight reach four, so nothing is lost however long out_stall lasts
// reset clears all sound state, power on, sample period back to 95
module four_channel_sound_generator (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  fcsg_pkg::req_t    in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output fcsg_pkg::rsp_t    out_data,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_wdata
);
	logic [15:0] period_q;
	logic go_s1;
	fcsg_pkg::req_t req_s1;
	logic rv;
	fcsg_pkg::rsp_t rd;
	fcsg_pkg::rsp_t [3:0] fifo_q;
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) period_q <= fcsg_pkg::SAMPLE_PERIOD_RST;
		else if (cfg_we) period_q <= cfg_wdata;
	end

	// queued words plus the two that may still be on their way
	assign in_stall = (cnt_q + {2'd0, rv} + {2'd0, go_s1}) >= 3'd4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) go_s1 <= 1'b0;
		else go_s1 <= in_valid && !in_stall;
	end
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) req_s1 <= in_data;
	end

	fcsg_core u_core (
		.clk(clk), .arst_n(arst_n), .go(go_s1), .req(req_s1),
		.sample_period(period_q), .rsp_valid(rv), .rsp(rd)
	);

	assign pop = cnt_q != 3'd0 && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 2'd0;
			rd_q <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (rv) wr_q <= wr_q + 2'd1;
			if (pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, rv} - {2'd0, pop};
		end
	end
	always_ff @(posedge clk) begin
		if (rv) fifo_q[wr_q] <= rd;
	end

	assign out_valid = cnt_q != 3'd0;
	assign out_data = fifo_q[rd_q];
endmodule

// File: hdl/fcsg_mixer.sv
// fcsg_mixer: channel outputs, stereo routing and volume scaling
// depends on fcsg_pkg
module fcsg_mixer (
	input  fcsg_pkg::mix_in_t m,
	output logic [14:0]       left,
	output logic [14:0]       right
);
	logic [3:0][3:0] o;
	logic [3:0] ws;
	logic [5:0] ls, rs;
	logic [8:0] lp, rp;

	always_comb begin
		ws = m.wave_phase[0] ? m.wave_byte[3:0] : m.wave_byte[7:4];
		for (int i = 0; i < 2; i++) begin
			o[i] = fcsg_pkg::duty_bit(m.duty[i], m.sq_phase[i]) ? m.env_vol[i] : 4'd0;
		end
		case (m.wave_level)
			2'd0:    o[2] = 4'd0;
			2'd1:    o[2] = ws;
			2'd2:    o[2] = ws >> 1;
			default: o[2] = ws >> 2;
		endcase
		o[3] = m.noise_bit ? 4'd0 : m.env_vol[2];
		for (int i = 0; i < 4; i++) begin
			if (!(m.active[i] && m.dac_on[i])) o[i] = 4'd0;
		end
		ls = 6'd0;
		rs = 6'd0;
		for (int i = 0; i < 4; i++) begin
			if (m.pan[i])     rs = rs + {2'd0, o[i]};
			if (m.pan[i + 4]) ls = ls + {2'd0, o[i]};
		end
		lp = ls * ({1'b0, m.vol[6:4]} + 4'd1);
		rp = rs * ({1'b0, m.vol[2:0]} + 4'd1);
		left  = {lp[8:0], 6'd0};
		right = {rp[8:0], 6'd0};
	end
endmodule

// File: hdl/fcsg_core.sv
// fcsg_core: register page, wave ram, channel state, frame and sample counters
// depends on fcsg_pkg and fcsg_mixer
module fcsg_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  fcsg_pkg::req_t    req,
	input  logic [15:0]       sample_period,
	output logic              rsp_valid,
	output fcsg_pkg::rsp_t    rsp
);
	logic [31:0][7:0] regs_q;
	logic [15:0][7:0] wave_q;
	logic        power_q;
	logic [fcsg_pkg::FRAME_CNT_W-1:0] ftc_q;
	logic [2:0]  fstep_q;
	logic [15:0] stc_q;
	logic [3:0]  act_q, dac_q, lon_q;
	logic [3:0][8:0]  len_q;
	logic [3:0][15:0] per_q;
	logic [1:0][1:0]  duty_q;
	logic [1:0][2:0]  sph_q;
	logic [2:0][3:0]  evol_q, etim_q;
	logic [4:0]  wph_q;
	logic [1:0]  wlv_q;
	logic [14:0] nsh_q;
	logic        nnar_q;

	fcsg_pkg::mix_in_t mi;
	logic [14:0] lmix, rmix;

	function automatic logic [7:0] rg(input logic [31:0][7:0] r, input logic [7:0] a);
		logic [7:0] o;
		o = 8'(a - 8'h10);
		return r[o[4:0]];
	endfunction

	// 11-bit frequency from a low byte and the next register's bits 2:0
	function automatic logic [10:0] fq(input logic [31:0][7:0] r, input logic [7:0] lo);
		logic [7:0] h;
		h = rg(r, 8'(lo + 8'h01));
		return {h[2:0], rg(r, lo)};
	endfunction

	logic is_tick, is_read, is_write;
	logic [7:0] a, v;
	logic mapped;
	assign a = req.address;
	assign v = req.write_data;
	assign is_tick  = go && req.req_type == fcsg_pkg::REQ_TICK && power_q;
	assign is_read  = go && req.req_type == fcsg_pkg::REQ_READ;
	assign is_write = go && req.req_type == fcsg_pkg::REQ_WRITE
		&& (power_q || a == fcsg_pkg::ADDR_NR52);
	assign mapped = a >= 8'h10 && a <= 8'h26 && a != 8'h15 && a != 8'h1F;

	// combinational next state
	logic [31:0][7:0] regs_d;
	logic [15:0][7:0] wave_d;
	logic        power_d;
	logic [fcsg_pkg::FRAME_CNT_W-1:0] ftc_d;
	logic [2:0]  fstep_d;
	logic [15:0] stc_d;
	logic [16:0] stc_inc;
	logic        emit;
	logic [3:0]  act_d, dac_d, lon_d;
	logic [3:0][8:0]  len_d;
	logic [3:0][15:0] per_d;
	logic [1:0][1:0]  duty_d;
	logic [1:0][2:0]  sph_d;
	logic [2:0][3:0]  evol_d, etim_d;
	logic [4:0]  wph_d;
	logic [1:0]  wlv_d;
	logic [14:0] nsh_d;
	logic        nnar_d;
	logic [7:0]  rdata;
	logic [7:0]  er;
	logic [2:0]  ep;
	logic        fx;
	logic [15:0] pdec;

	// the sample sees lengths and envelopes after this tick's frame step
	assign mi.active = act_d;
	assign mi.dac_on = dac_q;
	assign mi.duty = duty_q;
	assign mi.sq_phase = sph_q;
	assign mi.env_vol = evol_d;
	assign mi.wave_phase = wph_q;
	assign mi.wave_level = wlv_q;
	assign mi.wave_byte = wave_q[wph_q[4:1]];
	assign mi.noise_bit = nsh_q[0];
	assign mi.pan = rg(regs_q, fcsg_pkg::ADDR_NR51);
	assign mi.vol = rg(regs_q, fcsg_pkg::ADDR_NR50);

	fcsg_mixer u_mix (.m(mi), .left(lmix), .right(rmix));

	always_comb begin
		regs_d = regs_q; wave_d = wave_q; power_d = power_q;
		ftc_d = ftc_q; fstep_d = fstep_q; stc_d = stc_q;
		act_d = act_q; dac_d = dac_q; lon_d = lon_q; len_d = len_q; per_d = per_q;
		duty_d = duty_q; sph_d = sph_q; evol_d = evol_q; etim_d = etim_q;
		wph_d = wph_q; wlv_d = wlv_q; nsh_d = nsh_q; nnar_d = nnar_q;
		emit = 1'b0; stc_inc = 17'd0; er = 8'd0; ep = 3'd0; fx = 1'b0; pdec = 16'd0;

		// read path
		if (a >= 8'h30 && a <= 8'h3F) rdata = wave_q[a[3:0]];
		else if (!mapped) rdata = 8'hFF;
		else if (a == fcsg_pkg::ADDR_NR52)
			rdata = {power_q, 3'b111, act_q};
		else rdata = rg(regs_q, a);

		if (is_write) begin
			if (a >= 8'h30 && a <= 8'h3F) wave_d[a[3:0]] = v;
			else if (mapped) begin
				regs_d[5'(a - 8'h10)] = v;
				unique case (a)
					fcsg_pkg::ADDR_NR11, fcsg_pkg::ADDR_NR21: begin
						len_d[a == fcsg_pkg::ADDR_NR21] = 9'd64 - {3'd0, v[5:0]};
						duty_d[a == fcsg_pkg::ADDR_NR21] = v[7:6];
					end
					fcsg_pkg::ADDR_NR12: begin
						dac_d[0] = v[7:3] != 5'd0;
						if (!dac_d[0]) act_d[0] = 1'b0;
					end
					fcsg_pkg::ADDR_NR22: begin
						dac_d[1] = v[7:3] != 5'd0;
						if (!dac_d[1]) act_d[1] = 1'b0;
					end
					fcsg_pkg::ADDR_NR42: begin
						dac_d[3] = v[7:3] != 5'd0;
						if (!dac_d[3]) act_d[3] = 1'b0;
					end
					fcsg_pkg::ADDR_NR14, fcsg_pkg::ADDR_NR24: begin
						// frequency high bits come from the byte being written
						if (a == fcsg_pkg::ADDR_NR14) begin
							er = rg(regs_q, fcsg_pkg::ADDR_NR12);
							lon_d[0] = v[6];
							if (v[7]) begin
								act_d[0] = dac_q[0];
								if (len_q[0] == 9'd0) len_d[0] = 9'd64;
								per_d[0] = fcsg_pkg::sq_reload({v[2:0],
									rg(regs_q, fcsg_pkg::ADDR_NR13)});
								etim_d[0] = er[2:0] != 3'd0 ? {1'b0, er[2:0]} : 4'd8;
								evol_d[0] = er[7:4];
							end
						end else begin
							er = rg(regs_q, fcsg_pkg::ADDR_NR22);
							lon_d[1] = v[6];
							if (v[7]) begin
								act_d[1] = dac_q[1];
								if (len_q[1] == 9'd0) len_d[1] = 9'd64;
								per_d[1] = fcsg_pkg::sq_reload({v[2:0],
									rg(regs_q, fcsg_pkg::ADDR_NR23)});
								etim_d[1] = er[2:0] != 3'd0 ? {1'b0, er[2:0]} : 4'd8;
								evol_d[1] = er[7:4];
							end
						end
					end
					fcsg_pkg::ADDR_NR30: begin
						dac_d[2] = v[7];
						if (!v[7]) act_d[2] = 1'b0;
					end
					fcsg_pkg::ADDR_NR31: len_d[2] = 9'd256 - {1'b0, v};
					fcsg_pkg::ADDR_NR32: wlv_d = v[6:5];
					fcsg_pkg::ADDR_NR34: begin
						lon_d[2] = v[6];
						if (v[7]) begin
							act_d[2] = dac_q[2];
							if (len_q[2] == 9'd0) len_d[2] = 9'd256;
							per_d[2] = fcsg_pkg::wv_reload({v[2:0],
								rg(regs_q, fcsg_pkg::ADDR_NR33)});
							er = rg(regs_q, fcsg_pkg::ADDR_NR32);
							wlv_d = er[6:5];
							wph_d = 5'd0;
						end
					end
					fcsg_pkg::ADDR_NR41: len_d[3] = 9'd64 - {3'd0, v[5:0]};
					fcsg_pkg::ADDR_NR43: nnar_d = v[3];
					fcsg_pkg::ADDR_NR44: begin
						er = rg(regs_q, fcsg_pkg::ADDR_NR42);
						lon_d[3] = v[6];
						if (v[7]) begin
							act_d[3] = dac_q[3];
							if (len_q[3] == 9'd0) len_d[3] = 9'd64;
							etim_d[2] = er[2:0] != 3'd0 ? {1'b0, er[2:0]} : 4'd8;
							evol_d[2] = er[7:4];
							nsh_d = 15'h7FFF;
							per_d[3] = fcsg_pkg::noise_reload(rg(regs_q, fcsg_pkg::ADDR_NR43));
						end
					end
					fcsg_pkg::ADDR_NR52: begin
						if (v[7]) begin
							power_d = 1'b1;
							regs_d[5'(a - 8'h10)] = 8'h80;
						end else begin
							regs_d = '0; wave_d = '0; power_d = 1'b0;
							act_d = '0; dac_d = '0; lon_d = '0; len_d = '0; per_d = '0;
							duty_d = '0; sph_d = '0; evol_d = '0; etim_d = '0;
							wph_d = '0; wlv_d = '0; nsh_d = '0; nnar_d = 1'b0;
						end
					end
					default: ;
				endcase
			end
		end

		if (is_tick) begin
			if (ftc_q + 1'b1 >= fcsg_pkg::FRAME_CNT_W'(fcsg_pkg::FRAME_PERIOD)) begin
				ftc_d = '0;
				if (!fstep_q[0]) begin
					for (int i = 0; i < 4; i++) begin
						if (lon_q[i] && len_q[i] != 9'd0) begin
							len_d[i] = len_q[i] - 9'd1;
							if (len_q[i] == 9'd1) act_d[i] = 1'b0;
						end
					end
				end else if (fstep_q == 3'd7) begin
					for (int i = 0; i < 3; i++) begin
						er = rg(regs_q, i == 0 ? fcsg_pkg::ADDR_NR12 :
							i == 1 ? fcsg_pkg::ADDR_NR22 : fcsg_pkg::ADDR_NR42);
						ep = er[2:0];
						if (ep != 3'd0 && etim_q[i] != 4'd0) begin
							etim_d[i] = etim_q[i] - 4'd1;
							if (etim_q[i] == 4'd1) begin
								etim_d[i] = {1'b0, ep};
								if (er[3]) begin
									if (evol_q[i] != 4'd15) evol_d[i] = evol_q[i] + 4'd1;
								end else if (evol_q[i] != 4'd0) evol_d[i] = evol_q[i] - 4'd1;
							end
						end
					end
				end
				fstep_d = fstep_q + 3'd1;
			end else begin
				ftc_d = ftc_q + 1'b1;
			end

			stc_inc = {1'b0, stc_q} + 17'd1;
			if (stc_inc >= {1'b0, sample_period}) begin
				emit = 1'b1;
				stc_inc = stc_inc - {1'b0, sample_period};
			end
			stc_d = stc_inc[15:0];

			// a channel silenced by its length this tick does not advance
			for (int c = 0; c < 4; c++) begin
				if (act_d[c]) begin
					pdec = per_q[c] != 16'd0 ? per_q[c] - 16'd1 : 16'd0;
					per_d[c] = pdec;
					if (pdec == 16'd0) begin
						if (c == 0) begin
							per_d[0] = fcsg_pkg::sq_reload(fq(regs_q, fcsg_pkg::ADDR_NR13));
							sph_d[0] = sph_q[0] + 3'd1;
						end else if (c == 1) begin
							per_d[1] = fcsg_pkg::sq_reload(fq(regs_q, fcsg_pkg::ADDR_NR23));
							sph_d[1] = sph_q[1] + 3'd1;
						end else if (c == 2) begin
							per_d[2] = fcsg_pkg::wv_reload(fq(regs_q, fcsg_pkg::ADDR_NR33));
							wph_d = wph_q + 5'd1;
						end else begin
							fx = nsh_q[0] ^ nsh_q[1];
							per_d[3] = fcsg_pkg::noise_reload(rg(regs_q, fcsg_pkg::ADDR_NR43));
							nsh_d = {fx, nsh_q[14:1]};
							if (nnar_q) nsh_d[6] = fx;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= fcsg_pkg::REGS_RST;
			wave_q <= '0; power_q <= 1'b1; ftc_q <= '0; fstep_q <= '0; stc_q <= '0;
			act_q <= '0; dac_q <= '0; lon_q <= '0; len_q <= '0; per_q <= '0;
			duty_q <= '0; sph_q <= '0; evol_q <= '0; etim_q <= '0;
			wph_q <= '0; wlv_q <= '0; nsh_q <= '0; nnar_q <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			regs_q <= regs_d; wave_q <= wave_d; power_q <= power_d;
			ftc_q <= ftc_d; fstep_q <= fstep_d; stc_q <= stc_d;
			act_q <= act_d; dac_q <= dac_d; lon_q <= lon_d; len_q <= len_d; per_q <= per_d;
			duty_q <= duty_d; sph_q <= sph_d; evol_q <= evol_d; etim_q <= etim_d;
			wph_q <= wph_d; wlv_q <= wlv_d; nsh_q <= nsh_d; nnar_q <= nnar_d;
			rsp_valid <= is_read || emit;
		end
	end

	always_ff @(posedge clk) begin
		if (is_read) rsp <= '{1'b0, rdata, 15'd0, 15'd0};
		else rsp <= '{1'b1, 8'd0, lmix, rmix};
	end
endmodule

// File: hdl/fcsg_checker.sv
// fcsg_checker: port-level checks of the sound generator
// depends on fcsg_pkg; bound to four_channel_sound_generator
module fcsg_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_stall,
	input logic           out_valid,
	input logic           out_stall,
	input fcsg_pkg::rsp_t out_data
);
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result word changed");
	ap_read_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.result_kind |-> out_data.left_sample == 15'd0
		&& out_data.right_sample == 15'd0)
		else $error("read word carries sample data");
	ap_samp_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.result_kind |-> out_data.read_data == 8'd0
		&& out_data.left_sample[5:0] == 6'd0)
		else $error("sample word malformed");
	ap_stall_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");
endmodule

bind four_channel_sound_generator fcsg_checker u_fcsg_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
